// ----- rtl/core/mpc_pkg.sv -----
// Shared types and constants for the escape-time pixel colorizer.
// No dependencies; every other file of the block except mpc_fifo imports this package.
package mpc_pkg;

   localparam int FRAC_BITS = 44;
   localparam int Q_W       = 48;          // signed Q4.44 coordinate
   localparam int STEP_W    = 47;          // unsigned step width
   localparam int PIX_W     = 10;          // row and column index width
   localparam int CNT_W     = 13;          // iteration count width
   localparam int LEVEL_W   = 8;           // color level width
   localparam int ITER_LIMIT = 4096;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_EDGE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_EDGE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_STEP = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_STEP    = 2'd3;

   localparam logic signed [Q_W-1:0] LEFT_EDGE_RESET   = -48'sd4213328557638;
   localparam logic signed [Q_W-1:0] TOP_EDGE_RESET    = 48'sd11610842789315;
   localparam logic [STEP_W-1:0]     COLUMN_STEP_RESET = 47'd206158430;
   localparam logic [STEP_W-1:0]     ROW_STEP_RESET    = 47'd206158430;

   localparam int MID_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic signed [Q_W-1:0] left_edge;
      logic signed [Q_W-1:0] top_edge;
      logic [STEP_W-1:0]     column_step;
      logic [STEP_W-1:0]     row_step;
   } view_type;

   typedef struct packed {
      logic signed [Q_W-1:0] cr;
      logic signed [Q_W-1:0] ci;
   } point_type;

   typedef struct packed {
      logic [CNT_W-1:0]   escape_count;
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] green_level;
   } result_type;

endpackage

// ----- rtl/core/mpc_fifo.sv -----
// Small register queue with push/full and pop/empty sides.
// Generic width and depth; used between the stages of the colorizer.
module mpc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/core/mpc_front.sv -----
// Front end: takes pixel words and forms the point c in Q4.44 with saturation.
// Depends on mpc_pkg; feeds the point queue ahead of the iteration engine.
module mpc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  mpc_pkg::view_type          view,
   input  logic                       push,
   output logic                       full,
   input  logic [mpc_pkg::PIX_W-1:0]  pixel_row,
   input  logic [mpc_pkg::PIX_W-1:0]  pixel_col,
   output logic                       out_push,
   input  logic                       out_full,
   output mpc_pkg::point_type         out_point
);
   import mpc_pkg::*;

   localparam int PROD_W = STEP_W + PIX_W;
   localparam int SUM_W  = PROD_W + 2;

   logic              s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0] col_prod_ff, col_prod_in;
   logic [PROD_W-1:0] row_prod_ff, row_prod_in;
   logic              s2_valid_ff, s2_valid_in;
   point_type         point_ff, point_in;
   logic              s2_free, s1_move, accept;
   logic [SUM_W-1:0]  re_sum, im_sum;

   function automatic logic signed [Q_W-1:0] sat_q(input logic [SUM_W-1:0] v);
      if ((&v[SUM_W-1:Q_W-1]) || !(|v[SUM_W-1:Q_W-1])) begin
         return v[Q_W-1:0];
      end
      return v[SUM_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
   endfunction

   assign s2_free  = !s2_valid_ff || !out_full;
   assign s1_move  = s1_valid_ff && s2_free;
   assign full     = s1_valid_ff && !s2_free;
   assign accept   = push && !full;
   assign out_push = s2_valid_ff;
   assign out_point = point_ff;

   assign col_prod_in = PROD_W'(view.column_step) * PROD_W'(pixel_col);
   assign row_prod_in = PROD_W'(view.row_step) * PROD_W'(pixel_row);
   assign re_sum = SUM_W'(view.left_edge) + SUM_W'(col_prod_ff);
   assign im_sum = SUM_W'(view.top_edge) - SUM_W'(row_prod_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
      point_in    = point_ff;
      if (s1_move) begin
         point_in.cr = sat_q(re_sum);
         point_in.ci = sat_q(im_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_prod_ff <= col_prod_in;
         row_prod_ff <= row_prod_in;
      end
      point_ff <= point_in;
   end

endmodule

// ----- rtl/core/mpc_core.sv -----
// Iteration engine: runs z = z^2 + c in four phases per step, then maps the count to color.
// Depends on mpc_pkg; pops points from the point queue, pushes result words.
module mpc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_empty,
   output logic                in_pop,
   input  mpc_pkg::point_type  in_point,
   input  logic                out_full,
   output logic                out_push,
   output mpc_pkg::result_type out_result
);
   import mpc_pkg::*;

   localparam int Z_W     = Q_W + 1;                 // |z| < 16
   localparam int MAG_W   = Q_W;
   localparam int HALF_W  = MAG_W / 2;
   localparam int PP_W    = 2 * HALF_W;
   localparam int WIDE_W  = 2 * MAG_W;
   localparam int PROD_W  = WIDE_W - FRAC_BITS;
   localparam int STEP_W2 = PROD_W + 3;
   localparam int LANES   = 3;                       // zr^2, zi^2, zr*zi
   localparam logic [PROD_W:0] FOUR = (PROD_W + 1)'(4) << FRAC_BITS;

   localparam int V_W     = 17;
   localparam int DIV_W   = 11;
   localparam int RECIP_W = 12;
   localparam int QUO_W   = 11;
   localparam int RECIP_SHIFT = 18;
   localparam int FAC_W   = 8;
   localparam int D_W     = 11;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MAG  = 4'd1;
   localparam logic [3:0] ST_MUL  = 4'd2;
   localparam logic [3:0] ST_SUM  = 4'd3;
   localparam logic [3:0] ST_STEP = 4'd4;
   localparam logic [3:0] ST_COL0 = 4'd5;
   localparam logic [3:0] ST_COL1 = 4'd6;
   localparam logic [3:0] ST_COL2 = 4'd7;
   localparam logic [3:0] ST_PUSH = 4'd8;

   localparam logic [2:0] BAND_RED_RAMP = 3'd0;
   localparam logic [2:0] BAND_RED_MID  = 3'd1;
   localparam logic [2:0] BAND_RED_TOP  = 3'd2;
   localparam logic [2:0] BAND_GRN_1    = 3'd3;
   localparam logic [2:0] BAND_GRN_2    = 3'd4;
   localparam logic [2:0] BAND_GRN_3    = 3'd5;
   localparam logic [2:0] BAND_GRN_4    = 3'd6;

   logic [3:0]               state_ff, state_in;
   logic signed [Q_W-1:0]    cr_ff, cr_in, ci_ff, ci_in;
   logic signed [Z_W-1:0]    zr_ff, zr_in, zi_ff, zi_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [MAG_W-1:0]         mr_ff, mr_in, mi_ff, mi_in;
   logic                     xy_neg_ff, xy_neg_in;
   logic [PP_W-1:0]          pp_ff [LANES][4];
   logic [PP_W-1:0]          pp_in [LANES][4];
   logic [PROD_W-1:0]        prod_ff [LANES];
   logic [PROD_W-1:0]        prod_in [LANES];
   logic [2:0]               band_ff, band_in;
   logic                     black_ff, black_in;
   logic [V_W-1:0]           v_ff, v_in;
   logic [DIV_W-1:0]         div_ff, div_in;
   logic [RECIP_W-1:0]       recip_ff, recip_in;
   logic [LEVEL_W-1:0]       off_ff, off_in;
   logic [QUO_W-1:0]         q0_ff, q0_in;
   logic [LEVEL_W-1:0]       red_ff, red_in, green_ff, green_in;

   logic [MAG_W-1:0]         op_a [LANES];
   logic [MAG_W-1:0]         op_b [LANES];
   logic [WIDE_W-1:0]        wide [LANES];
   logic [Z_W-1:0]           zr_abs, zi_abs;
   logic [PROD_W:0]          mag_sum;
   logic                     escape;
   logic [STEP_W2-1:0]       zr_wide, zi_wide, cr_ext, ci_ext, twoxy;
   logic [CNT_W-1:0]         n_next;
   logic [CNT_W-1:0]         base;
   logic [FAC_W-1:0]         fac;
   logic [CNT_W-1:0]         d_full;
   logic [D_W+FAC_W-1:0]     v_prod;
   logic [V_W+RECIP_W-1:0]   q_prod;
   logic [2*DIV_W-1:0]       qd, rem;
   logic [QUO_W-1:0]         quo;
   logic [LEVEL_W-1:0]       level;

   assign in_pop     = (state_ff == ST_IDLE) && !in_empty;
   assign out_push   = (state_ff == ST_PUSH);
   assign out_result = '{escape_count: n_ff, red_level: red_ff, green_level: green_ff};

   // Magnitudes for the truncating sign-magnitude products
   assign zr_abs = zr_ff[Z_W-1] ? -zr_ff : zr_ff;
   assign zi_abs = zi_ff[Z_W-1] ? -zi_ff : zi_ff;

   assign op_a[0] = mr_ff;
   assign op_b[0] = mr_ff;
   assign op_a[1] = mi_ff;
   assign op_b[1] = mi_ff;
   assign op_a[2] = mr_ff;
   assign op_b[2] = mi_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         pp_in[l][0] = op_a[l][MAG_W-1:HALF_W] * op_b[l][MAG_W-1:HALF_W];
         pp_in[l][1] = op_a[l][MAG_W-1:HALF_W] * op_b[l][HALF_W-1:0];
         pp_in[l][2] = op_a[l][HALF_W-1:0] * op_b[l][MAG_W-1:HALF_W];
         pp_in[l][3] = op_a[l][HALF_W-1:0] * op_b[l][HALF_W-1:0];
         wide[l] = (WIDE_W'(pp_ff[l][0]) << MAG_W)
                 + (WIDE_W'(pp_ff[l][1]) << HALF_W)
                 + (WIDE_W'(pp_ff[l][2]) << HALF_W)
                 + WIDE_W'(pp_ff[l][3]);
         prod_in[l] = wide[l][WIDE_W-1:FRAC_BITS];
      end
   end

   // Escape test and z update
   assign mag_sum = {1'b0, prod_ff[0]} + {1'b0, prod_ff[1]};
   assign escape  = mag_sum > FOUR;
   assign cr_ext  = STEP_W2'(cr_ff);
   assign ci_ext  = STEP_W2'(ci_ff);
   assign twoxy   = STEP_W2'({prod_ff[2], 1'b0});
   assign zr_wide = STEP_W2'(prod_ff[0]) - STEP_W2'(prod_ff[1]) + cr_ext;
   assign zi_wide = xy_neg_ff ? (ci_ext - twoxy) : (ci_ext + twoxy);
   assign n_next  = n_ff + CNT_W'(1);

   // Color band selection
   always_comb begin
      band_in  = BAND_GRN_4;
      if (n_ff < CNT_W'(64)) begin
         band_in = BAND_RED_RAMP;
      end else if (n_ff < CNT_W'(128)) begin
         band_in = BAND_RED_MID;
      end else if (n_ff < CNT_W'(256)) begin
         band_in = BAND_RED_TOP;
      end else if (n_ff < CNT_W'(512)) begin
         band_in = BAND_GRN_1;
      end else if (n_ff < CNT_W'(1024)) begin
         band_in = BAND_GRN_2;
      end else if (n_ff < CNT_W'(2048)) begin
         band_in = BAND_GRN_3;
      end
      case (band_in)
         BAND_RED_MID: begin
            base = CNT_W'(64);   fac = FAC_W'(128); div_in = DIV_W'(126);
            recip_in = RECIP_W'((1 << RECIP_SHIFT) / 126); off_in = LEVEL_W'(128);
         end
         BAND_RED_TOP: begin
            base = CNT_W'(128);  fac = FAC_W'(62);  div_in = DIV_W'(127);
            recip_in = RECIP_W'((1 << RECIP_SHIFT) / 127); off_in = LEVEL_W'(193);
         end
         BAND_GRN_1: begin
            base = CNT_W'(256);  fac = FAC_W'(62);  div_in = DIV_W'(255);
            recip_in = RECIP_W'((1 << RECIP_SHIFT) / 255); off_in = LEVEL_W'(1);
         end
         BAND_GRN_2: begin
            base = CNT_W'(512);  fac = FAC_W'(63);  div_in = DIV_W'(511);
            recip_in = RECIP_W'((1 << RECIP_SHIFT) / 511); off_in = LEVEL_W'(64);
         end
         BAND_GRN_3: begin
            base = CNT_W'(1024); fac = FAC_W'(63);  div_in = DIV_W'(1023);
            recip_in = RECIP_W'((1 << RECIP_SHIFT) / 1023); off_in = LEVEL_W'(128);
         end
         BAND_GRN_4: begin
            base = CNT_W'(2048); fac = FAC_W'(63);  div_in = DIV_W'(2047);
            recip_in = RECIP_W'((1 << RECIP_SHIFT) / 2047); off_in = LEVEL_W'(192);
         end
         default: begin
            base = '0;           fac = '0;          div_in = DIV_W'(1);
            recip_in = '0;       off_in = '0;
         end
      endcase
   end

   assign black_in = (n_ff >= CNT_W'(ITER_LIMIT));
   assign d_full   = n_ff - base;
   assign v_prod   = (D_W + FAC_W)'(d_full[D_W-1:0]) * (D_W + FAC_W)'(fac);
   assign v_in     = v_prod[V_W-1:0];

   // Quotient estimate by reciprocal, low by at most one
   assign q_prod = (V_W + RECIP_W)'(v_ff) * (V_W + RECIP_W)'(recip_ff);
   assign q0_in  = q_prod[RECIP_SHIFT +: QUO_W];
   assign qd     = (2 * DIV_W)'(q0_ff) * (2 * DIV_W)'(div_ff);
   assign rem    = (2 * DIV_W)'(v_ff) - qd;
   assign quo    = (rem >= (2 * DIV_W)'(div_ff)) ? (q0_ff + QUO_W'(1)) : q0_ff;
   assign level  = quo[LEVEL_W-1:0] + off_ff;

   always_comb begin
      red_in   = '0;
      green_in = '0;
      if (!black_ff) begin
         case (band_ff)
            BAND_RED_RAMP: red_in = {n_ff[LEVEL_W-2:0], 1'b0};
            BAND_RED_MID,
            BAND_RED_TOP:  red_in = level;
            default: begin
               red_in   = '1;
               green_in = level;
            end
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      cr_in     = cr_ff;
      ci_in     = ci_ff;
      zr_in     = zr_ff;
      zi_in     = zi_ff;
      n_in      = n_ff;
      mr_in     = mr_ff;
      mi_in     = mi_ff;
      xy_neg_in = xy_neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!in_empty) begin
               cr_in    = in_point.cr;
               ci_in    = in_point.ci;
               zr_in    = '0;
               zi_in    = '0;
               n_in     = '0;
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            mr_in     = zr_abs[MAG_W-1:0];
            mi_in     = zi_abs[MAG_W-1:0];
            xy_neg_in = zr_ff[Z_W-1] ^ zi_ff[Z_W-1];
            state_in  = ST_MUL;
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_STEP;
         ST_STEP: begin
            if (escape) begin
               state_in = ST_COL0;
            end else begin
               zr_in    = zr_wide[Z_W-1:0];
               zi_in    = zi_wide[Z_W-1:0];
               n_in     = n_next;
               state_in = (n_next == CNT_W'(ITER_LIMIT)) ? ST_COL0 : ST_MAG;
            end
         end
         ST_COL0: state_in = ST_COL1;
         ST_COL1: state_in = ST_COL2;
         ST_COL2: state_in = ST_PUSH;
         ST_PUSH: begin
            if (!out_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      n_ff      <= n_in;
      mr_ff     <= mr_in;
      mi_ff     <= mi_in;
      xy_neg_ff <= xy_neg_in;
      pp_ff     <= pp_in;
      prod_ff   <= prod_in;
      if (state_ff == ST_COL0) begin
         band_ff  <= band_in;
         black_ff <= black_in;
         v_ff     <= v_in;
         div_ff   <= div_in;
         recip_ff <= recip_in;
         off_ff   <= off_in;
      end
      if (state_ff == ST_COL1) begin
         q0_ff <= q0_in;
      end
      if (state_ff == ST_COL2) begin
         red_ff   <= red_in;
         green_ff <= green_in;
      end
   end

endmodule

// ----- rtl/core/mandelbrot_pixel_colorizer.sv -----
// Top level of the escape-time pixel colorizer: view registers, front end,
// point queue, iteration engine and result queue. Depends on mpc_pkg and all mpc_ modules.
//
//   channel   handshake        payload
//   -------   --------------   ------------------------------------------------
//   pixel     push / full      req_pixel_row, req_pixel_col
//   result    pop / empty      rsp_escape_count, rsp_red_level, rsp_green_level
//   csr       valid / ready    csr_index, csr_wdata (ready is always high)
//
// The engine works on one pixel at a time; each step runs magnitude, partial
// products, product sum and update through one set of 24x24 multipliers.
// The front end forms c through its product and point registers and overlaps
// the engine through the point queue.
// Reset restores the default view and empties both queues.
// full rises when the front end and the point queue are occupied; the result queue
// holds finished words while pop stays low, and the engine waits only when it is full.
module mandelbrot_pixel_colorizer #(
   parameter int MID_QUEUE_DEPTH = mpc_pkg::MID_QUEUE_DEPTH,
   parameter int RSP_QUEUE_DEPTH = mpc_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [mpc_pkg::PIX_W-1:0]         req_pixel_row,
   input  logic [mpc_pkg::PIX_W-1:0]         req_pixel_col,
   output logic                              empty,
   input  logic                              pop,
   output logic [mpc_pkg::CNT_W-1:0]         rsp_escape_count,
   output logic [mpc_pkg::LEVEL_W-1:0]       rsp_red_level,
   output logic [mpc_pkg::LEVEL_W-1:0]       rsp_green_level,
   input  logic                              valid,
   output logic                              ready,
   input  logic [mpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mpc_pkg::*;

   view_type   view_ff, view_in;
   point_type  front_point, mid_point;
   result_type core_result, rsp_result;
   logic       front_push, mid_full, mid_empty, mid_pop;
   logic       core_push, out_full;

   assign ready = 1'b1;

   always_comb begin
      view_in = view_ff;
      if (valid && ready) begin
         case (csr_index)
            CSR_LEFT_EDGE:   view_in.left_edge   = csr_wdata[Q_W-1:0];
            CSR_TOP_EDGE:    view_in.top_edge    = csr_wdata[Q_W-1:0];
            CSR_COLUMN_STEP: view_in.column_step = csr_wdata[STEP_W-1:0];
            CSR_ROW_STEP:    view_in.row_step    = csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff <= '{left_edge: LEFT_EDGE_RESET, top_edge: TOP_EDGE_RESET,
                      column_step: COLUMN_STEP_RESET, row_step: ROW_STEP_RESET};
      end else begin
         view_ff <= view_in;
      end
   end

   mpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .view      (view_ff),
      .push      (push),
      .full      (full),
      .pixel_row (req_pixel_row),
      .pixel_col (req_pixel_col),
      .out_push  (front_push),
      .out_full  (mid_full),
      .out_point (front_point)
   );

   mpc_fifo #(
      .WIDTH ($bits(point_type)),
      .DEPTH (MID_QUEUE_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .full    (mid_full),
      .wr_data (front_point),
      .pop     (mid_pop),
      .empty   (mid_empty),
      .rd_data (mid_point)
   );

   mpc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .in_empty   (mid_empty),
      .in_pop     (mid_pop),
      .in_point   (mid_point),
      .out_full   (out_full),
      .out_push   (core_push),
      .out_result (core_result)
   );

   mpc_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (core_push),
      .full    (out_full),
      .wr_data (core_result),
      .pop     (pop),
      .empty   (empty),
      .rd_data (rsp_result)
   );

   assign rsp_escape_count = rsp_result.escape_count;
   assign rsp_red_level    = rsp_result.red_level;
   assign rsp_green_level  = rsp_result.green_level;

   // A pixel that never escaped is black
   a_black_at_limit : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_escape_count == CNT_W'(ITER_LIMIT)) |->
         (rsp_red_level == '0 && rsp_green_level == '0))
      else $error("limit count without black color");

   a_count_in_range : assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_escape_count <= CNT_W'(ITER_LIMIT)))
      else $error("escape count beyond limit");

   // Red bands below 256 carry no green
   a_red_band_no_green : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_escape_count < CNT_W'(256)) |-> (rsp_green_level == '0))
      else $error("green set in a red band");

   // The result queue takes no word while it is full; the engine holds its push
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      (core_push && out_full) |=> $stable(rsp_result) || !empty)
      else $error("result pushed into full queue");

endmodule

// ----- tb/sv/escape_checker_pkg.sv -----
// Scoreboard for the escape-time pixel colorizer: view copy, color predictor, expected words.
// Depends on mpc_pkg for the view, result and register index definitions.
package escape_checker_pkg;

   import mpc_pkg::*;

   class escape_checker;

      view_type   view;
      result_type expected_colors[$];
      int         mismatches;

      function new();
         view.left_edge   = LEFT_EDGE_RESET;
         view.top_edge    = TOP_EDGE_RESET;
         view.column_step = COLUMN_STEP_RESET;
         view.row_step    = ROW_STEP_RESET;
         mismatches       = 0;
      endfunction

      function void write_view(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_LEFT_EDGE: begin
               view.left_edge = data;
            end
            CSR_TOP_EDGE: begin
               view.top_edge = data;
            end
            CSR_COLUMN_STEP: begin
               view.column_step = data[STEP_W-1:0];
            end
            CSR_ROW_STEP: begin
               view.row_step = data[STEP_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function longint clamp_q(longint v);
         longint q_hi;
         longint q_lo;
         q_hi = (longint'(1) <<< (Q_W - 1)) - 1;
         q_lo = -q_hi - 1;
         if (v > q_hi) return q_hi;
         if (v < q_lo) return q_lo;
         return v;
      endfunction

      // truncate the magnitude product, then apply the sign
      function longint mul_q(longint a, longint b);
         logic [63:0]  ma;
         logic [63:0]  mb;
         logic [127:0] prod;
         longint       m;
         ma   = (a < 0) ? -a : a;
         mb   = (b < 0) ? -b : b;
         prod = {64'd0, ma} * {64'd0, mb};
         m    = prod[FRAC_BITS+63:FRAC_BITS];
         return ((a < 0) != (b < 0)) ? -m : m;
      endfunction

      function result_type escape_color(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
         longint     cr;
         longint     ci;
         longint     zr;
         longint     zi;
         longint     x2;
         longint     y2;
         longint     xy;
         longint     four;
         int         n;
         int         red;
         int         green;
         bit         escaped;
         result_type res;
         cr = clamp_q(longint'($signed(view.left_edge))
                      + longint'(view.column_step) * longint'(col));
         ci = clamp_q(longint'($signed(view.top_edge))
                      - longint'(view.row_step) * longint'(row));
         four    = longint'(4) <<< FRAC_BITS;
         zr      = 0;
         zi      = 0;
         n       = 0;
         escaped = 1'b0;
         while (!escaped && n < ITER_LIMIT) begin
            x2 = mul_q(zr, zr);
            y2 = mul_q(zi, zi);
            if (x2 + y2 > four) begin
               escaped = 1'b1;
            end else begin
               xy = mul_q(zr, zi);
               zr = x2 - y2 + cr;
               zi = 2 * xy + ci;
               n++;
            end
         end
         red   = 0;
         green = 0;
         // points that never escape stay black
         if (n < ITER_LIMIT) begin
            if (n < 64) begin
               red = 2 * n;
            end else if (n < 128) begin
               red = (n - 64) * 128 / 126 + 128;
            end else if (n < 256) begin
               red = (n - 128) * 62 / 127 + 193;
            end else begin
               red = 255;
               if (n < 512) begin
                  green = (n - 256) * 62 / 255 + 1;
               end else if (n < 1024) begin
                  green = (n - 512) * 63 / 511 + 64;
               end else if (n < 2048) begin
                  green = (n - 1024) * 63 / 1023 + 128;
               end else begin
                  green = (n - 2048) * 63 / 2047 + 192;
               end
            end
         end
         res.escape_count = n[CNT_W-1:0];
         res.red_level    = red[LEVEL_W-1:0];
         res.green_level  = green[LEVEL_W-1:0];
         return res;
      endfunction

      function void note_pixel(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
         expected_colors.push_back(escape_color(row, col));
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction

      function void check_color(result_type got);
         result_type want;
         if (expected_colors.size() == 0) begin
            if (mismatches < 10)
               $display("mismatch: unexpected word count=%0d red=%0d green=%0d",
                        got.escape_count, got.red_level, got.green_level);
            mismatches++;
            return;
         end
         want = expected_colors.pop_front();
         if (got.escape_count !== want.escape_count || got.red_level !== want.red_level
             || got.green_level !== want.green_level) begin
            if (mismatches < 10)
               $display("mismatch: count %0d/%0d red %0d/%0d green %0d/%0d (exp/act)",
                        want.escape_count, got.escape_count, want.red_level,
                        got.red_level, want.green_level, got.green_level);
            mismatches++;
         end
      endfunction

   endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top of the colorizer testbench: clock, reset, pixel and view drivers, result sink.
// Depends on mpc_pkg, escape_checker_pkg and the mandelbrot_pixel_colorizer RTL.
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import mpc_pkg::*;
   import escape_checker_pkg::*;

   localparam int WATCHDOG_LIMIT = 100000;
   localparam int LONG_HOLD      = 400;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push  = 1'b0;
   logic                   full;
   logic [PIX_W-1:0]       req_pixel_row = '0;
   logic [PIX_W-1:0]       req_pixel_col = '0;
   logic                   empty;
   logic                   pop   = 1'b0;
   logic [CNT_W-1:0]       rsp_escape_count;
   logic [LEVEL_W-1:0]     rsp_red_level;
   logic [LEVEL_W-1:0]     rsp_green_level;
   logic                   valid = 1'b0;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   escape_checker sb = new();
   int            hold_requests = 0;
   int            holds_done = 0;
   int            quiet_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   mandelbrot_pixel_colorizer i_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_col    (req_pixel_col),
      .empty            (empty),
      .pop              (pop),
      .rsp_escape_count (rsp_escape_count),
      .rsp_red_level    (rsp_red_level),
      .rsp_green_level  (rsp_green_level),
      .valid            (valid),
      .ready            (ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   task automatic offer(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
      push          <= 1'b1;
      req_pixel_row <= row;
      req_pixel_col <= col;
      do @(posedge clock); while (full);
      sb.note_pixel(row, col);
   endtask

   task automatic pause_input(int cycles);
      push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // drain first: the view may change only while no pixel is in flight
   task automatic set_view(logic [CSR_DATA_W-1:0] left, logic [CSR_DATA_W-1:0] top,
                           logic [CSR_DATA_W-1:0] cstep, logic [CSR_DATA_W-1:0] rstep);
      logic [CSR_DATA_W-1:0]  words[4];
      logic [CSR_INDEX_W-1:0] regs[4];
      words = '{left, top, cstep, rstep};
      regs  = '{CSR_LEFT_EDGE, CSR_TOP_EDGE, CSR_COLUMN_STEP, CSR_ROW_STEP};
      while (sb.pending() != 0) @(posedge clock);
      foreach (regs[i]) begin
         valid     <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= words[i];
         do @(posedge clock); while (!ready);
         sb.write_view(regs[i], words[i]);
      end
      valid <= 1'b0;
   endtask

   task automatic run_random(int items);
      logic [PIX_W-1:0] row;
      logic [PIX_W-1:0] col;
      result_type       guess;
      int               tries;
      int               burst_left;
      burst_left = $urandom_range(1, 12);
      repeat (items) begin
         if (burst_left == 0) begin
            pause_input($urandom_range(1, 6));
            burst_left = ($urandom_range(3) == 0) ? 30 : $urandom_range(1, 12);
         end
         // redraw most slow pixels so that deep counts stay a minority
         tries = 0;
         do begin
            row   = PIX_W'($urandom);
            col   = PIX_W'($urandom);
            guess = sb.escape_color(row, col);
            tries++;
         end while (tries < 6 && guess.escape_count > 1024 && $urandom_range(3) != 0);
         offer(row, col);
         burst_left--;
      end
      pause_input(1);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // view after reset, corner pixels and alternating bit patterns
      offer(10'd0, 10'd0);
      offer(10'd1023, 10'd1023);
      offer(10'd0, 10'd1023);
      offer(10'd1023, 10'd0);
      offer(10'h2AA, 10'h155);
      offer(10'h155, 10'h2AA);
      pause_input(1);

      // whole set in view; bit 47 of each step word must be dropped
      set_view(-48'sd43980465111040, 48'sd35184372088832,
               48'h8010_0000_0000, 48'h8010_0000_0000);
      offer(10'd512, 10'd640);
      offer(10'd512, 10'd0);
      pause_input(1);
      run_random(50);

      // saturated corner of the plane; hold results so the queues back up
      set_view(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
               48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
      hold_requests++;
      offer(10'd0, 10'd0);
      offer(10'd1023, 10'd1023);
      pause_input(1);
      run_random(30);

      set_view(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
               48'h8000_0000_0000, 48'h8000_0000_0000);
      offer(10'd1023, 10'd1023);
      offer(10'd0, 10'd0);
      pause_input(1);

      // narrow strip toward the cusp near -0.75: counts sweep the upper bands
      set_view(-48'sd13194139533312, 48'sd351843720888, 48'd0, 48'd343597384);
      offer(10'd0, 10'd777);
      offer(10'd1023, 10'd0);
      pause_input(1);
      run_random(40);

      set_view(LEFT_EDGE_RESET, TOP_EDGE_RESET, CSR_DATA_W'(COLUMN_STEP_RESET),
               CSR_DATA_W'(ROW_STEP_RESET));
      run_random(20);

      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      result_type  got;
      logic [15:0] pop_mask;
      int          mask_age;
      int          hold_left;
      pop_mask  = '1;
      mask_age  = 0;
      hold_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            got.escape_count = rsp_escape_count;
            got.red_level    = rsp_red_level;
            got.green_level  = rsp_green_level;
            sb.check_color(got);
         end
         if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (mask_age == 0) begin
            pop_mask = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
            mask_age = 64;
         end
         mask_age--;
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= pop_mask[mask_age % 16];
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (valid && ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

endmodule

// ----- mandelbrot_pixel_colorizer.f -----
rtl/core/mpc_pkg.sv
rtl/core/mpc_fifo.sv
rtl/core/mpc_front.sv
rtl/core/mpc_core.sv
rtl/core/mandelbrot_pixel_colorizer.sv
tb/sv/escape_checker_pkg.sv
tb/sv/tb_top.sv
